// ----- rtl/core/pei_pkg.sv -----
`default_nettype none
package pei_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int POW_BITS  = 30;
    localparam int DUR_BITS  = FRAC_BITS + 4;
    localparam int DMP_BITS  = FRAC_BITS + 1;
    localparam int FAC_BITS  = POW_BITS + 1;
    localparam int NUM_AXES  = 3;
    localparam int IDX_BITS  = 3;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [DUR_BITS-1:0]         dur_t;
    typedef logic [FAC_BITS-1:0]         fac_t;

    typedef enum logic [1:0] {
        KIND_FORCE = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_POS   = 2'd2,
        KIND_VEL   = 2'd3
    } kind_t;

    localparam logic [IDX_BITS-1:0] REG_ACCEL_X  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ACCEL_Y  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ACCEL_Z  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_INV_MASS = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_DAMPING  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DAMP = 2'd1,
        ST_LANE = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    typedef enum logic [2:0] {
        D_IDLE = 3'd0,
        D_ROOT = 3'd1,
        D_MULF = 3'd2,
        D_MULS = 3'd3,
        D_DONE = 3'd4
    } dphase_t;

    // {clipped, value}
    function automatic logic [WORD_BITS:0] sat_word(input logic signed [65:0] v);
        logic [WORD_BITS:0] r;
        if ((v[65:WORD_BITS-1] == '0) || (v[65:WORD_BITS-1] == '1))
            r = {1'b0, v[WORD_BITS-1:0]};
        else if (v[65])
            r = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
        else
            r = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pei_damp.sv -----
`default_nettype none
module pei_damp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pei_pkg::DMP_BITS-1:0]  damping,
    input  wire pei_pkg::dur_t                 dur,
    output logic                               done,
    output pei_pkg::fac_t                      factor
);
    import pei_pkg::*;

    dphase_t phase_reg, phase_next;
    logic [4:0]  k_reg, k_next;
    logic [4:0]  it_reg, it_next;
    logic [4:0]  i_reg, i_next;
    logic [63:0] x_reg, res_reg, one_reg;
    fac_t        f_reg, sq_reg;
    dur_t        dur_reg;
    fac_t        roots [0:FRAC_BITS];

    logic [63:0] trial, res_it, x_it;
    logic        ge;
    logic [DMP_BITS-1:0] dclip;
    fac_t        d_wide;
    logic [2*FAC_BITS-1:0] prod_r, prod_f, prod_s;
    logic [4:0]  ridx;

    assign dclip  = (damping > DMP_BITS'(1 << FRAC_BITS)) ? DMP_BITS'(1 << FRAC_BITS) : damping;
    assign d_wide = FAC_BITS'({dclip, {(POW_BITS-FRAC_BITS){1'b0}}});
    assign trial  = res_reg + one_reg;
    assign ge     = x_reg >= trial;
    assign res_it = ge ? ((res_reg >> 1) + one_reg) : (res_reg >> 1);
    assign x_it   = ge ? (x_reg - trial) : x_reg;
    assign ridx   = 5'(FRAC_BITS) - i_reg;
    assign prod_r = f_reg * roots[ridx];
    assign prod_f = f_reg * sq_reg;
    assign prod_s = sq_reg * sq_reg;
    assign done   = (phase_reg == D_DONE);
    assign factor = f_reg;

    always_comb
    begin
        phase_next = phase_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        i_next     = i_reg;
        case (phase_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    phase_next = D_ROOT;
                    k_next     = 5'd1;
                    it_next    = '0;
                end
            end
            D_ROOT:
            begin
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd31)
                begin
                    k_next = k_reg + 5'd1;
                    if (k_reg == 5'(FRAC_BITS))
                    begin
                        phase_next = D_MULF;
                        i_next     = '0;
                    end
                end
            end
            D_MULF:
            begin
                i_next = i_reg + 5'd1;
                if (i_reg == 5'(FRAC_BITS - 1))
                begin
                    phase_next = D_MULS;
                    i_next     = '0;
                end
            end
            D_MULS:
            begin
                i_next = i_reg + 5'd1;
                if (i_reg == 5'd3)
                    phase_next = D_DONE;
            end
            D_DONE:  phase_next = D_IDLE;
            default: phase_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= D_IDLE;
            k_reg     <= '0;
            it_reg    <= '0;
            i_reg     <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            k_reg     <= k_next;
            it_reg    <= it_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == D_IDLE && start)
            roots[0] <= d_wide;
        else if (phase_reg == D_ROOT && it_reg == 5'd31)
            roots[k_reg] <= res_it[FAC_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    dur_reg <= dur;
                    x_reg   <= 64'({d_wide, {POW_BITS{1'b0}}});
                    res_reg <= '0;
                    one_reg <= 64'd1 << 62;
                    f_reg   <= FAC_BITS'(1 << POW_BITS);
                    sq_reg  <= d_wide;
                end
            end
            D_ROOT:
            begin
                if (it_reg == 5'd31)
                begin
                    x_reg   <= {res_it[33:0], {POW_BITS{1'b0}}};
                    res_reg <= '0;
                    one_reg <= 64'd1 << 62;
                end
                else
                begin
                    x_reg   <= x_it;
                    res_reg <= res_it;
                    one_reg <= one_reg >> 2;
                end
            end
            D_MULF:
            begin
                if (dur_reg[i_reg[3:0]])
                    f_reg <= prod_r[POW_BITS+FAC_BITS-1:POW_BITS];
            end
            D_MULS:
            begin
                if (dur_reg[FRAC_BITS + 32'(i_reg[1:0])])
                    f_reg <= prod_f[POW_BITS+FAC_BITS-1:POW_BITS];
                sq_reg <= prod_s[POW_BITS+FAC_BITS-1:POW_BITS];
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/pei_lane.sv -----
`default_nettype none
module pei_lane (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire pei_pkg::word_t               pos,
    input  wire pei_pkg::word_t               vel,
    input  wire pei_pkg::word_t               force_sum,
    input  wire pei_pkg::word_t               accel,
    input  wire logic [pei_pkg::WORD_BITS-1:0] inv_mass,
    input  wire pei_pkg::dur_t                dur,
    input  wire pei_pkg::fac_t                factor,
    output logic                              done,
    output pei_pkg::word_t                    pos_new,
    output pei_pkg::word_t                    vel_new,
    output logic                              clipped
);
    import pei_pkg::*;

    logic [2:0] step_reg, step_next;
    logic       done_reg;
    logic signed [65:0] p1_reg, p2_reg, p3_reg, p4_reg;
    word_t      pos_reg, a_reg, nv_reg, vel_reg;
    logic       clip_reg;
    logic signed [65:0] r1, r2, r3, r4;
    logic [WORD_BITS:0] s_pos, s_a, s_nv;
    logic signed [65:0] d_s, f_s, m_s;

    assign d_s = 66'($signed({1'b0, dur}));
    assign f_s = 66'($signed({1'b0, factor}));
    assign m_s = 66'($signed({1'b0, inv_mass}));

    assign r1 = (p1_reg + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign r2 = (p2_reg + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign r3 = (p3_reg + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign r4 = (p4_reg + (66'sd1 <<< (POW_BITS - 1))) >>> POW_BITS;

    assign s_pos = sat_word(66'(pos) + r1);
    assign s_a   = sat_word(66'(accel) + r2);
    assign s_nv  = sat_word(66'(vel) + r3);

    assign step_next = (step_reg == 3'd0) ? (start ? 3'd1 : 3'd0)
                     : ((step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (step_reg == 3'd5);
        end
    end

    always_ff @(posedge clk)
    begin
        case (step_reg)
            3'd0:
            begin
                if (start)
                begin
                    p1_reg   <= 66'(vel) * d_s;
                    p2_reg   <= 66'(force_sum) * m_s;
                    clip_reg <= 1'b0;
                end
            end
            3'd1:
            begin
                pos_reg  <= s_pos[WORD_BITS-1:0];
                a_reg    <= s_a[WORD_BITS-1:0];
                clip_reg <= clip_reg | s_pos[WORD_BITS] | s_a[WORD_BITS];
            end
            3'd2: p3_reg <= 66'(a_reg) * d_s;
            3'd3:
            begin
                nv_reg   <= s_nv[WORD_BITS-1:0];
                clip_reg <= clip_reg | s_nv[WORD_BITS];
            end
            3'd4: p4_reg <= 66'(nv_reg) * f_s;
            3'd5: vel_reg <= r4[WORD_BITS-1:0];
            default: ;
        endcase
    end

    assign done    = done_reg;
    assign pos_new = pos_reg;
    assign vel_new = vel_reg;
    assign clipped = clip_reg;

endmodule
`default_nettype wire

// ----- rtl/core/particle_euler_integrator.sv -----
// Force, load and zero-duration items go from idle to the emit state, then load the outputs.
// Integrate: 16 damping roots (bit-serial square root unit), 20 factor multiplies, then
//   the per-axis lanes, before the result is loaded into the output registers.
// One item at a time: in_stall is high until the previous result is loaded for output.
// Reset (rst_n, asynchronous, active low): position, velocity, force sum, acceleration
//   and inverse mass clear to zero, damping to 1.0, no result pending.
`default_nettype none
module particle_euler_integrator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pei_pkg::IDX_BITS-1:0]  cfg_index,
    input  wire logic [pei_pkg::WORD_BITS-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire pei_pkg::word_t                vec_x,
    input  wire pei_pkg::word_t                vec_y,
    input  wire pei_pkg::word_t                vec_z,
    input  wire pei_pkg::dur_t                 duration,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pei_pkg::word_t                     pos_x,
    output pei_pkg::word_t                     pos_y,
    output pei_pkg::word_t                     pos_z,
    output pei_pkg::word_t                     vel_x,
    output pei_pkg::word_t                     vel_y,
    output pei_pkg::word_t                     vel_z,
    output logic                               bad_step,
    output logic                               saturated
);
    import pei_pkg::*;

    state_t state_reg, state_next;
    word_t  pos_reg [NUM_AXES];
    word_t  vel_reg [NUM_AXES];
    word_t  frc_reg [NUM_AXES];
    word_t  accel_reg [NUM_AXES];
    logic [WORD_BITS-1:0] inv_mass_reg;
    logic [DMP_BITS-1:0]  damping_reg;
    dur_t   dur_reg;
    logic   bad_reg, sat_reg;
    logic   out_valid_reg;
    word_t  opos_reg [NUM_AXES];
    word_t  ovel_reg [NUM_AXES];
    logic   obad_reg, osat_reg;

    word_t  vec [NUM_AXES];
    logic   accept, is_step, emit_load, damp_start, damp_done;
    fac_t   factor;
    logic   lane_done [NUM_AXES];
    word_t  lane_pos [NUM_AXES];
    word_t  lane_vel [NUM_AXES];
    logic   lane_clip [NUM_AXES];
    logic [WORD_BITS:0] fsum [NUM_AXES];

    assign vec[0]  = vec_x;
    assign vec[1]  = vec_y;
    assign vec[2]  = vec_z;
    assign accept  = in_valid && !in_stall;
    assign is_step = (kind_t'(kind) == KIND_STEP) && (duration != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = is_step ? ST_DAMP : ST_EMIT;
            ST_DAMP: if (damp_done) state_next = ST_LANE;
            ST_LANE: if (lane_done[0]) state_next = ST_EMIT;
            ST_EMIT: if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        damp_start = (state_reg == ST_IDLE) && accept && is_step;
        emit_load  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    end

    pei_damp u_damp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (damp_start),
        .damping (damping_reg),
        .dur     (duration),
        .done    (damp_done),
        .factor  (factor)
    );

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++)
        begin : g_lane
            pei_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .start     (damp_done),
                .pos       (pos_reg[g]),
                .vel       (vel_reg[g]),
                .force_sum (frc_reg[g]),
                .accel     (accel_reg[g]),
                .inv_mass  (inv_mass_reg),
                .dur       (dur_reg),
                .factor    (factor),
                .done      (lane_done[g]),
                .pos_new   (lane_pos[g]),
                .vel_new   (lane_vel[g]),
                .clipped   (lane_clip[g])
            );
            assign fsum[g] = sat_word(66'(frc_reg[g]) + 66'(vec[g]));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            inv_mass_reg  <= '0;
            damping_reg   <= DMP_BITS'(1 << FRAC_BITS);
            bad_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            dur_reg       <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_reg[i]   <= '0;
                vel_reg[i]   <= '0;
                frc_reg[i]   <= '0;
                accel_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACCEL_X:  accel_reg[0] <= cfg_data;
                    REG_ACCEL_Y:  accel_reg[1] <= cfg_data;
                    REG_ACCEL_Z:  accel_reg[2] <= cfg_data;
                    REG_INV_MASS: inv_mass_reg <= cfg_data;
                    REG_DAMPING:  damping_reg  <= cfg_data[DMP_BITS-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && accept)
            begin
                dur_reg <= duration;
                bad_reg <= 1'b0;
                sat_reg <= 1'b0;
                case (kind_t'(kind))
                    KIND_FORCE:
                    begin
                        sat_reg <= fsum[0][WORD_BITS] | fsum[1][WORD_BITS] | fsum[2][WORD_BITS];
                        for (int i = 0; i < NUM_AXES; i++)
                            frc_reg[i] <= fsum[i][WORD_BITS-1:0];
                    end
                    KIND_POS: for (int i = 0; i < NUM_AXES; i++) pos_reg[i] <= vec[i];
                    KIND_VEL: for (int i = 0; i < NUM_AXES; i++) vel_reg[i] <= vec[i];
                    KIND_STEP: bad_reg <= (duration == '0);
                    default: ;
                endcase
            end
            if (state_reg == ST_LANE && lane_done[0])
            begin
                sat_reg <= lane_clip[0] | lane_clip[1] | lane_clip[2];
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    pos_reg[i] <= lane_pos[i];
                    vel_reg[i] <= lane_vel[i];
                    frc_reg[i] <= '0;
                end
            end
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            obad_reg <= bad_reg;
            osat_reg <= sat_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                opos_reg[i] <= pos_reg[i];
                ovel_reg[i] <= vel_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = opos_reg[0];
    assign pos_y     = opos_reg[1];
    assign pos_z     = opos_reg[2];
    assign vel_x     = ovel_reg[0];
    assign vel_y     = ovel_reg[1];
    assign vel_z     = ovel_reg[2];
    assign bad_step  = obad_reg;
    assign saturated = osat_reg;

    a_lane_in_lane: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] |-> state_reg == ST_LANE)
        else $error("lane finished outside lane phase");
    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done[1] == lane_done[0]) && (lane_done[2] == lane_done[0]))
        else $error("lanes out of step");
    a_damp_in_damp: assert property (@(posedge clk) disable iff (!rst_n)
        damp_done |-> state_reg == ST_DAMP)
        else $error("damping unit finished outside damping phase");
    a_bad_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_step |-> !saturated)
        else $error("rejected step reports clipping");

endmodule
`default_nettype wire
